// ===== hw/rtl/lpc_pkg.sv =====
// Shared types and constants for the leader point clustering block.
// No dependencies; used by lpc_cell and leader_point_clustering_top.

package lpc_pkg;

   // seed store size
   localparam int MAX_SEEDS = 64;

   // field widths
   localparam int COORD_W = 12;
   localparam int ID_W    = 6;
   localparam int LIMIT_W = 26;
   localparam int MAG_W   = COORD_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;

   // seed index and seed count widths
   localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_W = $clog2(MAX_SEEDS + 1);

   // squared join distance after reset: a radius of 0.5 m
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(250000);

   // one point travelling down the seed chain
   typedef struct packed {
      logic                      valid;
      logic                      done;   // point has found or started its cluster
      logic                      seed;   // point was stored as a new seed
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [IDX_W-1:0]          idx;    // index of the cell being visited or claimed
      logic [CNT_W-1:0]          left;   // stored seeds not yet compared
   } lpc_token_type;

   // cluster number is the seed index, low bits
   function automatic logic [ID_W-1:0] to_cluster_id(input logic [IDX_W-1:0] idx);
      to_cluster_id = ID_W'(idx);
   endfunction

endpackage

// ===== hw/rtl/leader_point_clustering_top.sv =====
// Top level of the leader point clustering block: seed cell chain, seed count,
// limit register and result registers. Depends on lpc_pkg and lpc_cell.

// Usage:
//   Points enter on the req_ channel (valid/stall) and each gives exactly one
//   result on the rsp_ channel, in order. A point joins the earliest stored
//   seed within the squared distance limit, else becomes a new seed, else is
//   flagged with rsp_seed_overflow when all MAX_SEEDS seeds are in use.
//   req_frame_start empties the seed store before that point is handled.
//   csr_wr_en/csr_wr_data write the squared distance limit (mm^2); write it
//   only while no point is in flight.
//   Flow: a point walks the chain of MAX_SEEDS cells, each with a square stage
//   and a sum-and-compare stage, and its result is registered in the rsp_ or
//   holding registers as it leaves the last cell. One point is in the chain at
//   a time: a new point is taken only after the last one has left the chain.
//   Receiver stall: the result is held in rsp_ registers; a second result is
//   parked in a holding register, and req_stall stays high while it is full.
//   Reset: seed count cleared, limit set to 250000 mm^2 (0.5 m radius), no
//   point in flight, no result pending.

module leader_point_clustering_top
   import lpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_x_mm,
   input  logic signed [COORD_W-1:0]  req_y_mm,
   input  logic signed [COORD_W-1:0]  req_z_mm,
   input  logic                       req_frame_start,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ID_W-1:0]            rsp_cluster_id,
   output logic                       rsp_is_seed,
   output logic                       rsp_seed_overflow,

   input  logic                       csr_wr_en,
   input  logic [LIMIT_W-1:0]         csr_wr_data
);

   lpc_token_type          tok [0:MAX_SEEDS];

   logic [LIMIT_W-1:0]     limit_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   busy_ff;
   logic                   busy_in;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff;
   logic [ID_W-1:0]        rsp_id_in;
   logic                   rsp_seed_ff;
   logic                   rsp_seed_in;
   logic                   rsp_ovf_ff;
   logic                   rsp_ovf_in;

   logic                   pend_valid_ff;
   logic                   pend_valid_in;
   logic [ID_W-1:0]        pend_id_ff;
   logic [ID_W-1:0]        pend_id_in;
   logic                   pend_seed_ff;
   logic                   pend_seed_in;
   logic                   pend_ovf_ff;
   logic                   pend_ovf_in;

   logic                   accept;
   logic                   take;
   logic                   fin;
   logic [ID_W-1:0]        fin_id;
   logic                   fin_seed;
   logic                   fin_ovf;

   assign req_stall = busy_ff | pend_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign take      = rsp_valid_ff & ~rsp_stall;

   // inject the accepted item at the head of the chain
   always_comb begin
      tok[0].valid = accept;
      tok[0].done  = 1'b0;
      tok[0].seed  = 1'b0;
      tok[0].x     = req_x_mm;
      tok[0].y     = req_y_mm;
      tok[0].z     = req_z_mm;
      tok[0].idx   = '0;
      tok[0].left  = req_frame_start ? '0 : count_ff;
   end

   // seed cell chain
   for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
      lpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .limit   (limit_ff),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   // decode the item leaving the chain
   assign fin      = tok[MAX_SEEDS].valid;
   assign fin_id   = tok[MAX_SEEDS].done ? to_cluster_id(tok[MAX_SEEDS].idx) : '0;
   assign fin_seed = tok[MAX_SEEDS].seed;
   assign fin_ovf  = ~tok[MAX_SEEDS].done;

   // track the item in flight and the seed count
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in = 1'b1;
         if (req_frame_start) begin
            count_in = '0;
         end
      end
      if (fin) begin
         busy_in = 1'b0;
         if (fin_seed) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // load result registers, park a result while the receiver stalls
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_seed_in   = rsp_seed_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_seed_in  = pend_seed_ff;
      pend_ovf_in   = pend_ovf_ff;
      if (take) begin
         rsp_valid_in = 1'b0;
      end
      if (take && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = pend_id_ff;
         rsp_seed_in   = pend_seed_ff;
         rsp_ovf_in    = pend_ovf_ff;
         pend_valid_in = 1'b0;
      end
      if (fin) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = fin_id;
            rsp_seed_in  = fin_seed;
            rsp_ovf_in   = fin_ovf;
         end else begin
            pend_valid_in = 1'b1;
            pend_id_in    = fin_id;
            pend_seed_in  = fin_seed;
            pend_ovf_in   = fin_ovf;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_id_ff    <= rsp_id_in;
      rsp_seed_ff  <= rsp_seed_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      pend_id_ff   <= pend_id_in;
      pend_seed_ff <= pend_seed_in;
      pend_ovf_ff  <= pend_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cluster_id    = rsp_id_ff;
   assign rsp_is_seed       = rsp_seed_ff;
   assign rsp_seed_overflow = rsp_ovf_ff;

endmodule

// ===== hw/rtl/lpc_cell.sv =====
// One seed cell of the clustering chain: holds one seed and compares passing points.
// Depends on lpc_pkg for the token type and widths.

module lpc_cell
   import lpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [LIMIT_W-1:0]  limit,
   input  lpc_token_type       tok_in,
   output lpc_token_type       tok_out
);

   logic signed [COORD_W-1:0] seed_x_ff;
   logic signed [COORD_W-1:0] seed_y_ff;
   logic signed [COORD_W-1:0] seed_z_ff;
   logic                      seed_we;

   lpc_token_type             a_ff;
   lpc_token_type             a_in;
   logic [SQ_W-1:0]           sq_x_ff;
   logic [SQ_W-1:0]           sq_y_ff;
   logic [SQ_W-1:0]           sq_z_ff;
   logic [SQ_W-1:0]           sq_x_in;
   logic [SQ_W-1:0]           sq_y_in;
   logic [SQ_W-1:0]           sq_z_in;

   lpc_token_type             b_ff;
   lpc_token_type             b_in;
   logic [SUM_W-1:0]          dist_sq;
   logic                      hit;

   function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? 13'(-d) : 13'(d);
      abs_diff = m[MAG_W-1:0];
   endfunction

   // stage A: square the per-axis distance to this cell's seed
   always_comb begin
      logic [MAG_W-1:0] mx;
      logic [MAG_W-1:0] my;
      logic [MAG_W-1:0] mz;
      mx      = abs_diff(tok_in.x, seed_x_ff);
      my      = abs_diff(tok_in.y, seed_y_ff);
      mz      = abs_diff(tok_in.z, seed_z_ff);
      sq_x_in = mx * mx;
      sq_y_in = my * my;
      sq_z_in = mz * mz;
      a_in    = tok_in;
   end

   // stage B: sum, compare, and decide join, store or pass
   assign dist_sq = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign hit     = (dist_sq <= SUM_W'(limit));

   always_comb begin
      b_in    = a_ff;
      seed_we = 1'b0;
      if (a_ff.valid && !a_ff.done) begin
         if (a_ff.left != '0) begin
            if (hit) begin
               b_in.done = 1'b1;
            end else begin
               b_in.left = a_ff.left - 1'b1;
               b_in.idx  = a_ff.idx + 1'b1;
            end
         end else begin
            // first free cell: take the point as a new seed
            b_in.done = 1'b1;
            b_in.seed = 1'b1;
            seed_we   = 1'b1;
         end
      end
   end

   // seed registers, written only when a point claims this cell
   always_ff @(posedge clock) begin
      if (seed_we) begin
         seed_x_ff <= a_ff.x;
         seed_y_ff <= a_ff.y;
         seed_z_ff <= a_ff.z;
      end
   end

   // advance the point one stage per cycle, drop it at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // hold the squared distances beside the point
   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
   end

   assign tok_out = b_ff;

endmodule

// ===== dv/tb_leader_point_clustering_top.sv =====
// Self-checking testbench for leader_point_clustering_top: directed table, then random frames.
// Depends on lpc_pkg and the RTL; checks each result against its predictor or a typed label.

module tb_leader_point_clustering_top;
   import lpc_pkg::*;

   // one cluster label as it leaves the block
   typedef struct packed {
      logic [ID_W-1:0] cluster_id;
      logic            is_seed;
      logic            seed_overflow;
   } label_type;

   // one row of stimulus; typed rows carry a label read off by hand
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               frame_start;
      logic               typed;
      label_type          label;
   } point_row_type;

   localparam logic [COORD_W-1:0] C_MIN = 12'h800;
   localparam logic [COORD_W-1:0] C_MAX = 12'h7FF;
   localparam logic [COORD_W-1:0] C_NEG1 = 12'hFFF;
   localparam int NUM_DIR = 19;
   localparam int NUM_PHASES = 7;
   localparam int PHASE_ITEMS = 170;
   localparam int HOLD_CYCLES = 1000;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

   // directed rows, walked at the reset limit of 250000 mm^2
   localparam point_row_type DIR_ROWS [NUM_DIR] = '{
      '{12'd0,    12'd0,    12'd0,    1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
      '{12'd100,  12'd100,  12'd100,  1'b0, 1'b1, '{6'd0, 1'b0, 1'b0}},
      '{C_MAX,    C_MAX,    C_MAX,    1'b0, 1'b1, '{6'd1, 1'b1, 1'b0}},
      '{C_MIN,    C_MIN,    C_MIN,    1'b0, 1'b1, '{6'd2, 1'b1, 1'b0}},
      '{C_MAX,    C_MAX,    12'd1700, 1'b0, 1'b0, '0},
      '{C_MIN,    C_MAX,    C_MIN,    1'b0, 1'b0, '0},
      '{C_MAX,    C_MIN,    C_MAX,    1'b0, 1'b0, '0},
      '{12'd600,  12'd0,    12'd0,    1'b0, 1'b0, '0},
      '{12'd300,  12'd0,    12'd0,    1'b0, 1'b0, '0},   // two seeds in range
      '{12'd550,  12'd0,    12'd0,    1'b0, 1'b0, '0},
      '{12'd500,  12'd0,    12'd0,    1'b0, 1'b0, '0},   // exactly at the limit
      '{12'd0,    12'd501,  12'd0,    1'b0, 1'b0, '0},   // just past the limit
      '{C_NEG1,   C_NEG1,   C_NEG1,   1'b0, 1'b0, '0},
      '{C_MAX,    C_MAX,    C_MAX,    1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b1, '{6'd1, 1'b1, 1'b0}},
      '{-12'sd2000, 12'd2000, -12'sd2000, 1'b0, 1'b0, '0},
      '{12'd2000, -12'sd2000, 12'd2000, 1'b0, 1'b0, '0},
      '{12'd0,    12'd0,    12'd0,    1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
      '{12'd1,    12'd1,    12'd1,    1'b0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_x_mm;
   logic signed [COORD_W-1:0] req_y_mm;
   logic signed [COORD_W-1:0] req_z_mm;
   logic                      req_frame_start;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [ID_W-1:0]           rsp_cluster_id;
   logic                      rsp_is_seed;
   logic                      rsp_seed_overflow;
   logic                      csr_wr_en;
   logic [LIMIT_W-1:0]        csr_wr_data;

   // typed label of the item on the request side
   logic      cur_typed;
   label_type cur_label;

   // predictor state
   logic signed [COORD_W-1:0] seed_px [MAX_SEEDS];
   logic signed [COORD_W-1:0] seed_py [MAX_SEEDS];
   logic signed [COORD_W-1:0] seed_pz [MAX_SEEDS];
   int                        stored_seeds;
   logic [LIMIT_W-1:0]        join_limit;

   label_type pending_labels [$];
   int        label_errors = 0;

   // idling control, shared by sender and receiver
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_req = 1'b0;

   always #5 clock = ~clock;

   leader_point_clustering_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_mm          (req_x_mm),
      .req_y_mm          (req_y_mm),
      .req_z_mm          (req_z_mm),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cluster_id    (rsp_cluster_id),
      .rsp_is_seed       (rsp_is_seed),
      .rsp_seed_overflow (rsp_seed_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // label one point: earliest seed in range, else a new seed, else overflow
   function automatic label_type assign_cluster(input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py,
                                                input logic signed [COORD_W-1:0] pz,
                                                input logic fs);
      label_type lab;
      longint    dx, dy, dz, dsq;
      bit        found;
      lab = '0;
      found = 1'b0;
      if (fs) stored_seeds = 0;
      for (int i = 0; i < stored_seeds; i++) begin
         if (!found) begin
            dx  = longint'(px) - longint'(seed_px[i]);
            dy  = longint'(py) - longint'(seed_py[i]);
            dz  = longint'(pz) - longint'(seed_pz[i]);
            dsq = dx * dx + dy * dy + dz * dz;
            if (dsq <= longint'(join_limit)) begin
               found = 1'b1;
               lab.cluster_id = ID_W'(i);
            end
         end
      end
      if (!found) begin
         if (stored_seeds < MAX_SEEDS) begin
            seed_px[stored_seeds] = px;
            seed_py[stored_seeds] = py;
            seed_pz[stored_seeds] = pz;
            lab.cluster_id = ID_W'(stored_seeds);
            lab.is_seed = 1'b1;
            stored_seeds++;
         end else begin
            lab.seed_overflow = 1'b1;
         end
      end
      return lab;
   endfunction

   // predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      label_type want;
      label_type got;
      label_type lab;
      if (reset) begin
         stored_seeds = 0;
         join_limit = LIMIT_RESET;
      end else begin
         if (csr_wr_en) join_limit = csr_wr_data;
         if (req_valid && !req_stall) begin
            lab = assign_cluster(req_x_mm, req_y_mm, req_z_mm, req_frame_start);
            pending_labels = {pending_labels, (cur_typed ? cur_label : lab)};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_cluster_id, rsp_is_seed, rsp_seed_overflow};
            if (pending_labels.size() == 0) begin
               label_errors++;
               if (label_errors <= 10)
                  $display("unexpected result: id %0d seed %0b ovf %0b",
                           got.cluster_id, got.is_seed, got.seed_overflow);
            end else begin
               want = pending_labels.pop_front();
               if (got.cluster_id !== want.cluster_id || got.is_seed !== want.is_seed ||
                   got.seed_overflow !== want.seed_overflow) begin
                  label_errors++;
                  if (label_errors <= 10)
                     $display("mismatch: exp id %0d seed %0b ovf %0b, got id %0d seed %0b ovf %0b",
                              want.cluster_id, want.is_seed, want.seed_overflow,
                              got.cluster_id, got.is_seed, got.seed_overflow);
               end
            end
         end
      end
   end

   // receiver: random stall, or a long hold-off when requested
   initial begin
      int  hold_left;
      bit  hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // offer one item after a random gap and hold it until accepted
   task automatic offer_point(input point_row_type row);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_x_mm        <= row.x;
      req_y_mm        <= row.y;
      req_z_mm        <= row.z;
      req_frame_start <= row.frame_start;
      cur_typed       <= row.typed;
      cur_label       <= row.label;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every expected label has come back
   task automatic drain_labels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_join_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: v = -2048;
               1: v = 2047;
               2: v = 0;
               default: v = -1;
            endcase
         end
         1, 2: v = int'($urandom_range(0, 4095));
         default: v = int'($urandom_range(0, 4000)) - 2000;
      endcase
      return COORD_W'(v);
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(input logic signed [COORD_W-1:0] c,
                                                     input int spread);
      return COORD_W'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // stimulus
   initial begin
      point_row_type             row;
      logic signed [COORD_W-1:0] cx [6];
      logic signed [COORD_W-1:0] cy [6];
      logic signed [COORD_W-1:0] cz [6];
      logic [LIMIT_W-1:0]        limit;
      int                        sent;
      int                        frame_len;
      int                        num_centers;
      int                        spread;
      int                        k;
      bit                        paused;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_x_mm        = '0;
      req_y_mm        = '0;
      req_z_mm        = '0;
      req_frame_start = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      cur_typed       = 1'b0;
      cur_label       = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset limit
      send_idle_pct = 33;
      recv_idle_pct = 83;
      for (int r = 0; r < NUM_DIR; r++) offer_point(DIR_ROWS[r]);
      drain_labels();

      // random frames, one limit setting per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: limit = '0;
            1: limit = LIMIT_W'(1);
            2: limit = LIMIT_RESET;
            3: limit = LIMIT_W'(1000000);
            4: limit = LIMIT_W'(48000000);
            5: limit = LIMIT_MAX;
            default: limit = LIMIT_W'($urandom_range(0, 67108863));
         endcase
         write_join_limit(limit);
         if (p < 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 83;
         end else if (p < 5) begin
            send_idle_pct = 83;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long receiver hold-off while the sender keeps going
         if (p == NUM_PHASES - 1) hold_req = ~hold_req;

         sent = 0;
         paused = 1'b0;
         while (sent < PHASE_ITEMS) begin
            // tiny limits fill the store, so run long frames there
            if (p < 2 || $urandom_range(0, 9) == 0) frame_len = $urandom_range(66, 100);
            else frame_len = $urandom_range(1, 40);
            num_centers = $urandom_range(1, 6);
            for (int c = 0; c < num_centers; c++) begin
               cx[c] = rand_coord();
               cy[c] = rand_coord();
               cz[c] = rand_coord();
            end
            case ($urandom_range(0, 2))
               0: spread = 50;
               1: spread = 400;
               default: spread = 1500;
            endcase
            for (int n = 0; n < frame_len; n++) begin
               row = '0;
               if ($urandom_range(0, 7) == 0) begin
                  // noise point anywhere, with a stray frame start now and then
                  row.x = rand_coord();
                  row.y = rand_coord();
                  row.z = rand_coord();
                  row.frame_start = ($urandom_range(0, 19) == 0);
               end else begin
                  k = $urandom_range(0, num_centers - 1);
                  row.x = near_coord(cx[k], spread);
                  row.y = near_coord(cy[k], spread);
                  row.z = near_coord(cz[k], spread);
               end
               // open the frame, except in the odd broken frame
               if (n == 0 && $urandom_range(0, 9) != 0) row.frame_start = 1'b1;
               offer_point(row);
               sent++;
               // sender pause until every result is back
               if (!paused && sent >= PHASE_ITEMS / 2) begin
                  paused = 1'b1;
                  drain_labels();
               end
            end
         end
         drain_labels();
      end

      repeat (2 * MAX_SEEDS + 8) @(posedge clock);
      if (label_errors == 0 && pending_labels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_cell.sv
hw/rtl/leader_point_clustering_top.sv
dv/tb_leader_point_clustering_top.sv
